// File: rtl/hbo_pkg.sv
// Shared types, widths and constants for the hash bucket overflow counter.
// Depends on nothing; every other file of the block imports it.

package hbo_pkg;

   // Field and state widths.
   localparam int HASH_W       = 64;
   localparam int BYTE_W       = 8;
   localparam int SEED_W       = 16;
   localparam int MULT_W       = 8;
   localparam int OCC_W        = 7;
   localparam int TOTAL_W      = 23;
   localparam int BUCKET_OUT_W = 16;
   localparam int DIGIT_W      = 16;
   localparam int DIGIT_CNT_W  = 2;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 16;

   // Table size and queue depth between the front and back parts.
   localparam int NUM_BUCKETS_DEFAULT = 1024;
   localparam int QUEUE_DEPTH         = 2;

   // Register reset values.
   localparam logic [SEED_W-1:0] SEED_RESET     = SEED_W'(9469);
   localparam logic [MULT_W-1:0] MULT_RESET     = MULT_W'(63);
   localparam logic [OCC_W-1:0]  CAPACITY_RESET = OCC_W'(87);

   // Saturation value of the overflow total.
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

   // Last 16-bit digit of the hash handled by the remainder unit.
   localparam logic [DIGIT_CNT_W-1:0] LAST_DIGIT = DIGIT_CNT_W'(HASH_W / DIGIT_W - 1);

   // Input command codes.
   localparam logic CMD_NAME_BYTE = 1'b0;
   localparam logic CMD_CLEAR     = 1'b1;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_HASH_SEED       = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_HASH_MULTIPLIER = CSR_INDEX_W'(1);
   localparam logic [CSR_INDEX_W-1:0] CSR_BUCKET_CAPACITY = CSR_INDEX_W'(2);

   // One word passed from the front part to the back part.
   typedef struct packed {
      logic              is_clear;
      logic [HASH_W-1:0] hash;
   } queue_entry_type;

   // Status reported by the back part to the front part.
   typedef struct packed {
      logic init_busy;
   } back_status_type;

   // Back part sequencer states.
   typedef enum logic [2:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_MOD,
      BK_REDUCE,
      BK_READ,
      BK_CHECK,
      BK_RESULT
   } back_state_type;

endpackage

// File: rtl/hbo_front.sv
// Front part: accepts input words and keeps the running hash of the current name.
// Depends on hbo_pkg; feeds finished hashes and clear commands to hbo_queue.

module hbo_front import hbo_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  logic                 req_command,
   input  logic [BYTE_W-1:0]    req_name_byte,
   input  logic                 req_last_byte,
   input  logic [SEED_W-1:0]    hash_seed,
   input  logic [MULT_W-1:0]    hash_multiplier,
   input  back_status_type      back_status,
   input  logic                 q_full,
   output logic                 q_push,
   output queue_entry_type      q_entry
);

   logic [HASH_W-1:0]        running_hash_ff, running_hash_in;
   logic                     in_name_ff, in_name_in;
   logic                     accept;
   logic [HASH_W-1:0]        base;
   logic [HASH_W-1:0]        byte_ext;
   logic [HASH_W+MULT_W-1:0] product;
   logic [HASH_W-1:0]        hash_new;

   // Input is held off while the queue is full or the table is being initialized.
   assign req_full = q_full | back_status.init_busy;
   assign accept   = req_push & ~req_full;

   // Multiply-add hash step with the byte taken as a signed char.
   assign base     = in_name_ff ? running_hash_ff : HASH_W'(hash_seed);
   assign byte_ext = {{(HASH_W-BYTE_W){req_name_byte[BYTE_W-1]}}, req_name_byte};
   assign product  = base * hash_multiplier;
   assign hash_new = product[HASH_W-1:0] + byte_ext;

   // A word goes to the back part for a clear or for the last byte of a name.
   always_comb begin
      q_push           = accept & ((req_command == CMD_CLEAR) | req_last_byte);
      q_entry.is_clear = (req_command == CMD_CLEAR);
      q_entry.hash     = hash_new;
   end

   // Running hash update.
   always_comb begin
      running_hash_in = running_hash_ff;
      in_name_in      = in_name_ff;
      if (accept) begin
         if ((req_command == CMD_CLEAR) || req_last_byte) begin
            running_hash_in = HASH_W'(hash_seed);
            in_name_in      = 1'b0;
         end else begin
            running_hash_in = hash_new;
            in_name_in      = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_name_ff <= 1'b0;
      end else begin
         in_name_ff <= in_name_in;
      end
      running_hash_ff <= running_hash_in;
   end

endmodule

// File: rtl/hbo_queue.sv
// Short first-in first-out queue between the front and back parts.
// Depends on hbo_pkg for the entry type and the depth.

module hbo_queue import hbo_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  queue_entry_type push_entry,
   output logic            full,
   input  logic            pop,
   output logic            valid,
   output queue_entry_type head
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

   queue_entry_type  entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == DEPTH_CNT);
   assign valid   = (count_ff != '0);
   assign head    = entries_ff[rd_ptr_ff];
   assign do_push = push & ~full;
   assign do_pop  = pop & valid;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// File: rtl/hbo_back.sv
// Back part: bucket selection, occupancy store, totals and the result register.
// Depends on hbo_pkg; takes words from hbo_queue.

module hbo_back import hbo_pkg::*; #(
   parameter int NUM_BUCKETS = NUM_BUCKETS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [OCC_W-1:0]        bucket_capacity,
   input  logic                    q_valid,
   input  queue_entry_type         q_head,
   output logic                    q_pop,
   output back_status_type         back_status,
   output logic                    rsp_empty,
   input  logic                    rsp_pop,
   output logic [BUCKET_OUT_W-1:0] rsp_placed_bucket,
   output logic                    rsp_overflowed,
   output logic [TOTAL_W-1:0]      rsp_overflow_total,
   output logic                    rsp_table_full
);

   localparam int BW = $clog2(NUM_BUCKETS);
   localparam bit IS_POW2 = ((NUM_BUCKETS & (NUM_BUCKETS - 1)) == 0);
   localparam int PAIR_W = 2 * DIGIT_W;
   localparam logic [BW-1:0]     LAST_IDX = BW'(NUM_BUCKETS - 1);
   localparam logic [PAIR_W-1:0] N_PAIR   = PAIR_W'(NUM_BUCKETS);
   // Floor of 2^32 over the bucket count; the quotient it gives is low by at most one.
   localparam logic [PAIR_W-1:0] RECIP    = PAIR_W'((64'd1 << PAIR_W) / NUM_BUCKETS);

   back_state_type state_ff, state_in;

   logic [HASH_W-1:0]       hash_ff, hash_in;
   logic [BW-1:0]           rem_ff, rem_in;
   logic [DIGIT_CNT_W-1:0]  digit_cnt_ff, digit_cnt_in;
   logic [PAIR_W-1:0]       quot_ff, quot_in;
   logic [BW-1:0]           idx_ff, idx_in;
   logic [BW-1:0]           step_ff, step_in;
   logic                    init_ff, init_in;
   logic [TOTAL_W-1:0]      total_ff, total_in;
   logic                    full_flag_ff, full_flag_in;
   logic [BW-1:0]           res_bucket_ff, res_bucket_in;
   logic                    res_ovf_ff, res_ovf_in;
   logic                    out_valid_ff, out_valid_in;
   logic [BUCKET_OUT_W-1:0] out_bucket_ff, out_bucket_in;
   logic                    out_ovf_ff, out_ovf_in;
   logic [TOTAL_W-1:0]      out_total_ff, out_total_in;
   logic                    out_full_ff, out_full_in;

   logic [OCC_W-1:0]        occ_mem_ff [NUM_BUCKETS];
   logic [OCC_W-1:0]        rd_data_ff;
   logic                    mem_we, mem_re;
   logic [OCC_W-1:0]        mem_wdata;

   logic [PAIR_W-1:0]       mod_pair;
   logic [2*PAIR_W-1:0]     quot_prod;
   logic [PAIR_W-1:0]       quot_times_n;
   logic [PAIR_W-1:0]       mod_diff;
   logic [PAIR_W-1:0]       mod_fix;
   logic [BW-1:0]           rem_next;
   logic                    has_room;
   logic                    out_load;

   // Remainder by the bucket count, one 16-bit digit of the hash at a time from the top.
   // The partial remainder and the next digit form a 32-bit value; a reciprocal multiply
   // estimates its quotient, and a subtract with one correction leaves the new remainder.
   assign mod_pair     = {DIGIT_W'(rem_ff), hash_ff[HASH_W-1 -: DIGIT_W]};
   assign quot_prod    = mod_pair * RECIP;
   assign quot_times_n = quot_ff * N_PAIR;
   assign mod_diff     = mod_pair - quot_times_n;
   assign mod_fix      = (mod_diff >= N_PAIR) ? (mod_diff - N_PAIR) : mod_diff;
   assign rem_next     = mod_fix[BW-1:0];

   assign has_room = (rd_data_ff < bucket_capacity);

   assign back_status.init_busy = init_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_CLEAR: begin
            if (idx_ff == LAST_IDX) begin
               state_in = BK_IDLE;
            end
         end
         BK_IDLE: begin
            if (q_valid) begin
               if (q_head.is_clear) begin
                  state_in = BK_CLEAR;
               end else if (IS_POW2) begin
                  state_in = BK_READ;
               end else begin
                  state_in = BK_MOD;
               end
            end
         end
         BK_MOD: begin
            state_in = BK_REDUCE;
         end
         BK_REDUCE: begin
            if (digit_cnt_ff == LAST_DIGIT) begin
               state_in = BK_READ;
            end else begin
               state_in = BK_MOD;
            end
         end
         BK_READ: begin
            state_in = BK_CHECK;
         end
         BK_CHECK: begin
            if (has_room || (step_ff == LAST_IDX)) begin
               state_in = BK_RESULT;
            end else begin
               state_in = BK_READ;
            end
         end
         BK_RESULT: begin
            if (out_load) begin
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // Sequencer outputs: queue pop, memory strobes and result register load.
   always_comb begin
      q_pop     = 1'b0;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_wdata = '0;
      out_load  = 1'b0;
      unique case (state_ff)
         BK_CLEAR: begin
            mem_we = 1'b1;
         end
         BK_IDLE: begin
            q_pop = q_valid;
         end
         BK_MOD: begin
         end
         BK_REDUCE: begin
         end
         BK_READ: begin
            mem_re = 1'b1;
         end
         BK_CHECK: begin
            mem_we    = has_room;
            mem_wdata = rd_data_ff + 1'b1;
         end
         BK_RESULT: begin
            out_load = ~out_valid_ff | rsp_pop;
         end
         default: begin
         end
      endcase
   end

   // Datapath registers.
   always_comb begin
      hash_in       = hash_ff;
      rem_in        = rem_ff;
      digit_cnt_in  = digit_cnt_ff;
      quot_in       = quot_ff;
      idx_in        = idx_ff;
      step_in       = step_ff;
      init_in       = init_ff;
      total_in      = total_ff;
      full_flag_in  = full_flag_ff;
      res_bucket_in = res_bucket_ff;
      res_ovf_in    = res_ovf_ff;
      out_valid_in  = out_valid_ff & ~rsp_pop;
      out_bucket_in = out_bucket_ff;
      out_ovf_in    = out_ovf_ff;
      out_total_in  = out_total_ff;
      out_full_in   = out_full_ff;
      case (state_ff)
         BK_CLEAR: begin
            idx_in = idx_ff + 1'b1;
            if (idx_ff == LAST_IDX) begin
               init_in = 1'b0;
            end
         end
         BK_IDLE: begin
            if (q_valid) begin
               if (q_head.is_clear) begin
                  idx_in       = '0;
                  total_in     = '0;
                  full_flag_in = 1'b0;
               end else begin
                  hash_in      = q_head.hash;
                  rem_in       = '0;
                  digit_cnt_in = '0;
                  idx_in       = q_head.hash[BW-1:0];
                  step_in      = '0;
               end
            end
         end
         BK_MOD: begin
            quot_in = quot_prod[2*PAIR_W-1:PAIR_W];
         end
         BK_REDUCE: begin
            rem_in       = rem_next;
            idx_in       = rem_next;
            hash_in      = hash_ff << DIGIT_W;
            digit_cnt_in = digit_cnt_ff + 1'b1;
         end
         BK_CHECK: begin
            if (has_room) begin
               res_bucket_in = idx_ff;
               res_ovf_in    = (step_ff != '0);
               if ((step_ff != '0) && (total_ff != TOTAL_MAX)) begin
                  total_in = total_ff + 1'b1;
               end
            end else if (step_ff == LAST_IDX) begin
               res_bucket_in = '0;
               res_ovf_in    = 1'b0;
               full_flag_in  = 1'b1;
            end else begin
               idx_in  = (idx_ff == LAST_IDX) ? '0 : idx_ff + 1'b1;
               step_in = step_ff + 1'b1;
            end
         end
         BK_RESULT: begin
            if (out_load) begin
               out_valid_in  = 1'b1;
               out_bucket_in = BUCKET_OUT_W'(res_bucket_ff);
               out_ovf_in    = res_ovf_ff;
               out_total_in  = total_ff;
               out_full_in   = full_flag_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_CLEAR;
         idx_ff       <= '0;
         init_ff      <= 1'b1;
         total_ff     <= '0;
         full_flag_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         init_ff      <= init_in;
         total_ff     <= total_in;
         full_flag_ff <= full_flag_in;
         out_valid_ff <= out_valid_in;
      end
      hash_ff       <= hash_in;
      rem_ff        <= rem_in;
      digit_cnt_ff  <= digit_cnt_in;
      quot_ff       <= quot_in;
      step_ff       <= step_in;
      res_bucket_ff <= res_bucket_in;
      res_ovf_ff    <= res_ovf_in;
      out_bucket_ff <= out_bucket_in;
      out_ovf_ff    <= out_ovf_in;
      out_total_ff  <= out_total_in;
      out_full_ff   <= out_full_in;
   end

   // Occupancy store: one write port and one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         occ_mem_ff[idx_ff] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= occ_mem_ff[idx_ff];
      end
   end

   assign rsp_empty          = ~out_valid_ff;
   assign rsp_placed_bucket  = out_bucket_ff;
   assign rsp_overflowed     = out_ovf_ff;
   assign rsp_overflow_total = out_total_ff;
   assign rsp_table_full     = out_full_ff;

endmodule

// File: rtl/hash_bucket_overflow_counter.sv
// Top level of the hash bucket overflow counter: configuration registers and wiring.
// Depends on hbo_pkg, hbo_front, hbo_queue and hbo_back.

// Key names enter one byte per word on the req_ queue; a byte that does not end a name is
// taken while req_full is low, since the front part folds it into the 64-bit running hash.
// The last byte of a name, or a clear command, goes through a two-word queue to the back
// part. There a name is started in the idle state; the remainder of the hash by NUM_BUCKETS
// follows (four 16-bit digits, each a reciprocal multiply and then a subtract with one
// correction; skipped when NUM_BUCKETS is a power of two); each bucket is probed by a read
// of the occupancy memory's registered read port and a check; and then the result register
// is loaded. The load waits while the previous result word has not been popped. A clear
// sweeps the occupancy memory, one entry a cycle, starting after the cycle that takes it.
// After reset the same sweep runs and req_full stays high until it ends; configuration
// writes are taken throughout.

module hash_bucket_overflow_counter import hbo_pkg::*; #(
   parameter int NUM_BUCKETS = NUM_BUCKETS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_push,
   output logic                    req_full,
   input  logic                    req_command,
   input  logic [BYTE_W-1:0]       req_name_byte,
   input  logic                    req_last_byte,
   output logic                    rsp_empty,
   input  logic                    rsp_pop,
   output logic [BUCKET_OUT_W-1:0] rsp_placed_bucket,
   output logic                    rsp_overflowed,
   output logic [TOTAL_W-1:0]      rsp_overflow_total,
   output logic                    rsp_table_full,
   input  logic                    csr_write_en,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata
);

   logic [SEED_W-1:0] seed_ff, seed_in;
   logic [MULT_W-1:0] mult_ff, mult_in;
   logic [OCC_W-1:0]  cap_ff, cap_in;

   logic              q_push, q_full, q_pop, q_valid;
   queue_entry_type   q_entry, q_head;
   back_status_type   back_status;

   // Configuration register writes; unknown indexes are ignored.
   always_comb begin
      seed_in = seed_ff;
      mult_in = mult_ff;
      cap_in  = cap_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_HASH_SEED:       seed_in = csr_wdata[SEED_W-1:0];
            CSR_HASH_MULTIPLIER: mult_in = csr_wdata[MULT_W-1:0];
            CSR_BUCKET_CAPACITY: cap_in  = csr_wdata[OCC_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= SEED_RESET;
         mult_ff <= MULT_RESET;
         cap_ff  <= CAPACITY_RESET;
      end else begin
         seed_ff <= seed_in;
         mult_ff <= mult_in;
         cap_ff  <= cap_in;
      end
   end

   hbo_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_command     (req_command),
      .req_name_byte   (req_name_byte),
      .req_last_byte   (req_last_byte),
      .hash_seed       (seed_ff),
      .hash_multiplier (mult_ff),
      .back_status     (back_status),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_entry         (q_entry)
   );

   hbo_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .full       (q_full),
      .pop        (q_pop),
      .valid      (q_valid),
      .head       (q_head)
   );

   hbo_back #(
      .NUM_BUCKETS (NUM_BUCKETS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .bucket_capacity    (cap_ff),
      .q_valid            (q_valid),
      .q_head             (q_head),
      .q_pop              (q_pop),
      .back_status        (back_status),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_placed_bucket  (rsp_placed_bucket),
      .rsp_overflowed     (rsp_overflowed),
      .rsp_overflow_total (rsp_overflow_total),
      .rsp_table_full     (rsp_table_full)
   );

endmodule
